/* src/sraq_pkg.sv */
// Shared codes, types and defaults of the selective-repeat ARQ engine.
package sraq_pkg;

  // Default sequence number width; window is half the sequence space.
  localparam int unsigned SEQ_BITS_DEF = 4;

  // Event codes of an input word.
  localparam logic [2:0] MODE_PKT_READY  = 3'd0;
  localparam logic [2:0] MODE_LINK_READY = 3'd1;
  localparam logic [2:0] MODE_FRAME      = 3'd2;
  localparam logic [2:0] MODE_DATA_TMO   = 3'd3;
  localparam logic [2:0] MODE_ACK_TMO    = 3'd4;

  // Received frame kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  // Action codes of an output word.
  localparam logic [2:0] ACT_DATA    = 3'd0;
  localparam logic [2:0] ACT_ACK     = 3'd1;
  localparam logic [2:0] ACT_NAK     = 3'd2;
  localparam logic [2:0] ACT_DELIVER = 3'd3;
  localparam logic [2:0] ACT_STOP    = 3'd4;
  localparam logic [2:0] ACT_START   = 3'd5;
  localparam logic [2:0] ACT_STATUS  = 3'd6;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LINK,
    OP_DATA_NEW,
    OP_DATA_TMO,
    OP_DATA_NAK,
    OP_ACK,
    OP_NAK,
    OP_START,
    OP_DELIVER,
    OP_STOP,
    OP_STATUS
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   mark;      // set the arrival bit of the received sequence number
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       good;
    logic [1:0] kind;
    logic       can_send;      // outstanding below window
    logic       nak_ok;        // no NAK sent since last delivery
    logic       seq_off;       // received seq is not the expected one
    logic       accept;        // received seq in window and not yet arrived
    logic       head_arrived;  // frame at the receive lower edge has arrived
    logic       any;           // at least one delivery in this event
    logic       want_ok;       // NAK-requested seq lies in sender window
    logic       stop_ok;       // ack covers the sender lower edge
    logic       emit_ok;       // output register can take a word
  } dp_stat_t;

endpackage

/* src/sraq_if.sv */
// Input event and output command channels of the ARQ engine.
interface sraq_in_if import sraq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic                frame_good;
  logic [1:0]          frame_type;
  logic [SEQ_BITS-1:0] frame_seq;
  logic [SEQ_BITS-1:0] ack_seq;
  logic [SEQ_BITS-1:0] timeout_seq;

  modport source (
    output valid, mode, frame_good, frame_type, frame_seq, ack_seq, timeout_seq,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_good, frame_type, frame_seq, ack_seq, timeout_seq,
    output ready
  );
endinterface

interface sraq_out_if import sraq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [2:0]          action;
  logic [SEQ_BITS-1:0] seq_number;
  logic [SEQ_BITS-1:0] ack_number;
  logic [SEQ_BITS-2:0] buffer_slot;
  logic                network_enable;
  logic                last;

  modport source (
    output valid, action, seq_number, ack_number, buffer_slot, network_enable, last,
    input  ready
  );
  modport sink (
    input  valid, action, seq_number, ack_number, buffer_slot, network_enable, last,
    output ready
  );
endinterface

/* src/selective_repeat_arq_engine_core.sv */
// Top level of the selective-repeat ARQ control engine.
//
// Selective-repeat ARQ engine with SEQ_BITS-bit sequence numbers and a window of
// half the sequence space (8 buffers at the default width). Each input word is one
// event: packet ready, link ready, frame received (already length and CRC checked),
// data timeout or ack timeout. The engine answers with a burst of command words in
// order: send data / ack / NAK or an ack-timer start, in-order deliveries by buffer
// slot, a further ack-timer start after deliveries, data-timer stops, closed by one
// status word (last = 1) that carries network_enable. Payload buffers, CRC and
// timers live outside. One event is in flight at a time: the input is ready only
// between bursts. Besides emitting its output words, the sequencer takes the event,
// passes decision steps that emit nothing, and closes each loop that it enters; the
// delivery loop and the ack loop each retire one sequence number per cycle, and a
// stalled output holds the sequencer. The last output word may still be waiting when
// the next event is taken.
module selective_repeat_arq_engine_core import sraq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sraq_in_if.sink    in_i,
  sraq_out_if.source out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  // Sequence the event: one datapath operation per cycle.
  sraq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // Hold window state, arrival map and the output word.
  sraq_dp #(
    .SEQ_BITS (SEQ_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (in_i.mode),
    .frame_good_i  (in_i.frame_good),
    .frame_type_i  (in_i.frame_type),
    .frame_seq_i   (in_i.frame_seq),
    .ack_seq_i     (in_i.ack_seq),
    .timeout_seq_i (in_i.timeout_seq),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_o         (out_o)
  );

endmodule

/* src/sraq_ctrl.sv */
// Event sequencer of the ARQ engine: decides the datapath operation per cycle.
module sraq_ctrl import sraq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_DLV    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_RESEND = 3'd4;
  localparam logic [2:0] S_STOP   = 3'd5;
  localparam logic [2:0] S_STATUS = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.mark = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_FIRST;
        end
      end
      S_FIRST: begin
        case (stat_i.mode)
          MODE_PKT_READY: begin
            if (!stat_i.can_send) begin
              state_d = S_STATUS;
            end else if (stat_i.emit_ok) begin
              cmd_o.op = OP_DATA_NEW;
              state_d  = S_STATUS;
            end
          end
          MODE_LINK_READY: begin
            cmd_o.op = OP_LINK;
            state_d  = S_STATUS;
          end
          MODE_FRAME: begin
            if (!stat_i.good) begin
              if (!stat_i.nak_ok) begin
                state_d = S_STATUS;
              end else if (stat_i.emit_ok) begin
                cmd_o.op = OP_NAK;
                state_d  = S_STATUS;
              end
            end else if (stat_i.kind == KIND_DATA) begin
              if (stat_i.emit_ok) begin
                cmd_o.op   = (stat_i.seq_off && stat_i.nak_ok) ? OP_NAK : OP_START;
                cmd_o.mark = stat_i.accept;
                state_d    = stat_i.accept ? S_DLV : S_STOP;
              end
            end else if (stat_i.kind == KIND_NAK) begin
              state_d = S_RESEND;
            end else begin
              state_d = S_STOP;
            end
          end
          MODE_DATA_TMO: begin
            if (stat_i.emit_ok) begin
              cmd_o.op = OP_DATA_TMO;
              state_d  = S_STATUS;
            end
          end
          MODE_ACK_TMO: begin
            if (stat_i.emit_ok) begin
              cmd_o.op = OP_ACK;
              state_d  = S_STATUS;
            end
          end
          default: begin
            state_d = S_STATUS;
          end
        endcase
      end
      S_DLV: begin
        if (!stat_i.head_arrived) begin
          state_d = stat_i.any ? S_DSTART : S_STOP;
        end else if (stat_i.emit_ok) begin
          cmd_o.op = OP_DELIVER;
        end
      end
      S_DSTART: begin
        if (stat_i.emit_ok) begin
          cmd_o.op = OP_START;
          state_d  = S_STOP;
        end
      end
      S_RESEND: begin
        if (!stat_i.want_ok) begin
          state_d = S_STOP;
        end else if (stat_i.emit_ok) begin
          cmd_o.op = OP_DATA_NAK;
          state_d  = S_STOP;
        end
      end
      S_STOP: begin
        if (!stat_i.stop_ok) begin
          state_d = S_STATUS;
        end else if (stat_i.emit_ok) begin
          cmd_o.op = OP_STOP;
        end
      end
      S_STATUS: begin
        if (stat_i.emit_ok) begin
          cmd_o.op = OP_STATUS;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/sraq_dp.sv */
// Window state, arrival map and output register of the ARQ engine.
module sraq_dp import sraq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          mode_i,
  input  logic                frame_good_i,
  input  logic [1:0]          frame_type_i,
  input  logic [SEQ_BITS-1:0] frame_seq_i,
  input  logic [SEQ_BITS-1:0] ack_seq_i,
  input  logic [SEQ_BITS-1:0] timeout_seq_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  sraq_out_if.source          out_o
);

  localparam int unsigned W   = SEQ_BITS;
  localparam int unsigned SW  = SEQ_BITS - 1;
  localparam int unsigned NRB = 2 ** SW;
  localparam logic [W-1:0] WIN = W'(NRB);

  function automatic logic in_win(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  // Window state
  logic [W-1:0]   sle_q, sle_d, nts_q, nts_d, rle_q, rle_d, rue_q, rue_d;
  logic [W-1:0]   outst_q, outst_d;
  logic [NRB-1:0] arrived_q, arrived_d;
  logic           nak_ok_q, nak_ok_d, link_q, link_d, any_q, any_d;

  // Held event
  logic [2:0]   mode_q, mode_d;
  logic         good_q, good_d;
  logic [1:0]   kind_q, kind_d;
  logic [W-1:0] fseq_q, fseq_d, fack_q, fack_d, tseq_q, tseq_d;

  // Output register
  logic          ovalid_q, ovalid_d;
  logic [2:0]    oact_q, oact_d;
  logic [W-1:0]  oseq_q, oseq_d, oack_q, oack_d;
  logic [SW-1:0] oslot_q, oslot_d;
  logic          one_q, one_d, olast_q, olast_d;

  logic [W-1:0] piggy, want;
  logic         emit_ok, emit;

  assign piggy   = rle_q - W'(1);
  assign want    = fack_q + W'(1);
  assign emit_ok = !ovalid_q || out_o.ready;

  assign stat_o.mode         = mode_q;
  assign stat_o.good         = good_q;
  assign stat_o.kind         = kind_q;
  assign stat_o.can_send     = outst_q < WIN;
  assign stat_o.nak_ok       = nak_ok_q;
  assign stat_o.seq_off      = fseq_q != rle_q;
  assign stat_o.accept       = in_win(rle_q, fseq_q, rue_q) && !arrived_q[fseq_q[SW-1:0]];
  assign stat_o.head_arrived = arrived_q[rle_q[SW-1:0]];
  assign stat_o.any          = any_q;
  assign stat_o.want_ok      = in_win(sle_q, want, nts_q);
  assign stat_o.stop_ok      = in_win(sle_q, fack_q, nts_q);
  assign stat_o.emit_ok      = emit_ok;

  always_comb begin
    sle_d     = sle_q;
    nts_d     = nts_q;
    rle_d     = rle_q;
    rue_d     = rue_q;
    outst_d   = outst_q;
    arrived_d = arrived_q;
    nak_ok_d  = nak_ok_q;
    link_d    = link_q;
    any_d     = any_q;
    mode_d    = mode_q;
    good_d    = good_q;
    kind_d    = kind_q;
    fseq_d    = fseq_q;
    fack_d    = fack_q;
    tseq_d    = tseq_q;
    emit      = 1'b1;
    oact_d    = ACT_STATUS;
    oseq_d    = '0;
    oack_d    = '0;
    oslot_d   = '0;
    one_d     = 1'b0;
    olast_d   = 1'b0;

    case (cmd_i.op)
      OP_LATCH: begin
        emit   = 1'b0;
        mode_d = mode_i;
        good_d = frame_good_i;
        kind_d = frame_type_i;
        fseq_d = frame_seq_i;
        fack_d = ack_seq_i;
        tseq_d = timeout_seq_i;
        any_d  = 1'b0;
      end
      OP_LINK: begin
        emit   = 1'b0;
        link_d = 1'b1;
      end
      OP_DATA_NEW: begin
        oact_d  = ACT_DATA;
        oseq_d  = nts_q;
        oack_d  = piggy;
        oslot_d = nts_q[SW-1:0];
        outst_d = outst_q + W'(1);
        nts_d   = nts_q + W'(1);
        link_d  = 1'b0;
      end
      OP_DATA_TMO: begin
        oact_d  = ACT_DATA;
        oseq_d  = tseq_q;
        oack_d  = piggy;
        oslot_d = tseq_q[SW-1:0];
        link_d  = 1'b0;
      end
      OP_DATA_NAK: begin
        oact_d  = ACT_DATA;
        oseq_d  = want;
        oack_d  = piggy;
        oslot_d = want[SW-1:0];
        link_d  = 1'b0;
      end
      OP_ACK: begin
        oact_d = ACT_ACK;
        oack_d = piggy;
        link_d = 1'b0;
      end
      OP_NAK: begin
        oact_d   = ACT_NAK;
        oack_d   = piggy;
        nak_ok_d = 1'b0;
        link_d   = 1'b0;
      end
      OP_START: begin
        oact_d = ACT_START;
      end
      OP_DELIVER: begin
        oact_d                       = ACT_DELIVER;
        oseq_d                       = rle_q;
        oslot_d                      = rle_q[SW-1:0];
        nak_ok_d                     = 1'b1;
        arrived_d[rle_q[SW-1:0]]     = 1'b0;
        rle_d                        = rle_q + W'(1);
        rue_d                        = rue_q + W'(1);
        any_d                        = 1'b1;
      end
      OP_STOP: begin
        oact_d  = ACT_STOP;
        oseq_d  = sle_q;
        outst_d = outst_q - W'(1);
        sle_d   = sle_q + W'(1);
      end
      OP_STATUS: begin
        oact_d  = ACT_STATUS;
        one_d   = (outst_q < WIN) && link_q;
        olast_d = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    // Arrival of the received frame is recorded alongside its NAK or ack-timer start.
    if (cmd_i.mark) begin
      arrived_d[fseq_q[SW-1:0]] = 1'b1;
    end

    // Hold the word until taken; a new word loads only when the register is free.
    if (emit) begin
      ovalid_d = 1'b1;
    end else begin
      ovalid_d = ovalid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sle_q     <= '0;
      nts_q     <= '0;
      rle_q     <= '0;
      rue_q     <= WIN;
      outst_q   <= '0;
      arrived_q <= '0;
      nak_ok_q  <= 1'b1;
      link_q    <= 1'b0;
      any_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      sle_q     <= sle_d;
      nts_q     <= nts_d;
      rle_q     <= rle_d;
      rue_q     <= rue_d;
      outst_q   <= outst_d;
      arrived_q <= arrived_d;
      nak_ok_q  <= nak_ok_d;
      link_q    <= link_d;
      any_q     <= any_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    good_q <= good_d;
    kind_q <= kind_d;
    fseq_q <= fseq_d;
    fack_q <= fack_d;
    tseq_q <= tseq_d;
    if (emit) begin
      oact_q  <= oact_d;
      oseq_q  <= oseq_d;
      oack_q  <= oack_d;
      oslot_q <= oslot_d;
      one_q   <= one_d;
      olast_q <= olast_d;
    end
  end

  assign out_o.valid          = ovalid_q;
  assign out_o.action         = oact_q;
  assign out_o.seq_number     = oseq_q;
  assign out_o.ack_number     = oack_q;
  assign out_o.buffer_slot    = oslot_q;
  assign out_o.network_enable = one_q;
  assign out_o.last           = olast_q;

endmodule

/* src/sraq_checker.sv */
// Port-level checks of the ARQ engine and their binding to the top level.
module sraq_checker import sraq_pkg::*; #(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [2:0]          out_action_i,
  input logic [SEQ_BITS-1:0] out_seq_i,
  input logic [SEQ_BITS-2:0] out_slot_i,
  input logic                out_ne_i,
  input logic                out_last_i
);

  // A waiting word stays valid and keeps its action.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_action_i))
    else $error("output word changed while stalled");

  // Drop ready after taking an event until its burst is through.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted event");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_action_i == ACT_STATUS)))
    else $error("last flag does not match status word");

  a_ne_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_action_i != ACT_STATUS) |-> !out_ne_i)
    else $error("network enable outside status word");

  a_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_action_i == ACT_DATA) || (out_action_i == ACT_DELIVER))
    |-> out_slot_i == out_seq_i[SEQ_BITS-2:0])
    else $error("buffer slot does not follow sequence number");

endmodule

bind selective_repeat_arq_engine_core sraq_checker #(
  .SEQ_BITS (SEQ_BITS)
) u_sraq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_action_i (out_o.action),
  .out_seq_i    (out_o.seq_number),
  .out_slot_i   (out_o.buffer_slot),
  .out_ne_i     (out_o.network_enable),
  .out_last_i   (out_o.last)
);

/* dv/tb_top.sv */
// Testbench for the selective-repeat ARQ engine: directed and random events, predicted command words.
`timescale 1ns / 1ps

module tb_top;
  import sraq_pkg::*;

  localparam int unsigned SEQ_W = SEQ_BITS_DEF;
  localparam int unsigned WIN   = 1 << (SEQ_W - 1);
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 30;

  // Event codes and frame kinds that the package leaves unnamed.
  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [1:0] KIND_RSVD    = 2'd3;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [SEQ_W-2:0] slot_t;

  typedef struct {
    logic [2:0] mode;
    logic       good;
    logic [1:0] kind;
    seq_t       fseq;
    seq_t       fack;
    seq_t       tseq;
  } arq_ev_t;

  typedef struct {
    logic [2:0] action;
    seq_t       seq;
    seq_t       ack;
    slot_t      slot;
    logic       ne;
    logic       last;
  } arq_cmd_t;

  logic clk_i;
  logic rst_ni;

  sraq_in_if  in_if ();
  sraq_out_if out_if ();

  selective_repeat_arq_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted engine state: sender and receiver window edges, arrivals, flags.
  seq_t        snd_lo;
  seq_t        snd_next;
  seq_t        rcv_lo;
  seq_t        rcv_hi;
  int unsigned outstanding;
  bit          arrived [WIN];
  bit          nak_ok;
  bit          link_rdy;

  // Command words still owed by the engine, oldest first.
  arq_cmd_t pending_cmds [$];

  bit          stalls_on;
  int unsigned mismatches;
  int unsigned n_events;
  int unsigned n_frames;
  int unsigned n_words;
  int unsigned n_delivered;
  int unsigned n_stops;
  int unsigned burst_len;
  int unsigned max_burst;
  int unsigned quiet_cycles;
  int          stall_left;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // True when b lies in the circular interval [a, c).
  function automatic bit in_win(seq_t a, seq_t b, seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic void reset_model();
    snd_lo      = '0;
    snd_next    = '0;
    rcv_lo      = '0;
    rcv_hi      = seq_t'(WIN);
    outstanding = 0;
    nak_ok      = 1'b1;
    link_rdy    = 1'b0;
    for (int i = 0; i < WIN; i++) arrived[i] = 1'b0;
  endfunction

  function automatic void push_cmd(logic [2:0] act, seq_t sq, seq_t ak, slot_t sl,
                                   logic ne, logic lst);
    arq_cmd_t c;
    c.action = act;
    c.seq    = sq;
    c.ack    = ak;
    c.slot   = sl;
    c.ne     = ne;
    c.last   = lst;
    pending_cmds.push_back(c);
    burst_len++;
  endfunction

  // Piggybacked ack is the frame expected minus one.
  function automatic seq_t piggy_ack();
    return rcv_lo - seq_t'(1);
  endfunction

  // A data send restarts that frame's timer outside and uses up the link.
  function automatic void emit_data(seq_t sq);
    push_cmd(ACT_DATA, sq, piggy_ack(), slot_t'(sq), 1'b0, 1'b0);
    link_rdy = 1'b0;
  endfunction

  function automatic void emit_ctrl(logic [2:0] act);
    push_cmd(act, '0, piggy_ack(), '0, 1'b0, 1'b0);
    if (act == ACT_NAK) nak_ok = 1'b0;
    link_rdy = 1'b0;
  endfunction

  function automatic void predict_frame(arq_ev_t ev);
    seq_t want;
    bit   any;
    any = 1'b0;
    // Drop a corrupted frame; complain once until the next delivery.
    if (!ev.good) begin
      if (nak_ok) emit_ctrl(ACT_NAK);
      return;
    end
    if (ev.kind == KIND_DATA) begin
      if (ev.fseq != rcv_lo && nak_ok) emit_ctrl(ACT_NAK);
      else push_cmd(ACT_START, '0, '0, '0, 1'b0, 1'b0);
      if (in_win(rcv_lo, ev.fseq, rcv_hi) && !arrived[slot_t'(ev.fseq)]) begin
        arrived[slot_t'(ev.fseq)] = 1'b1;
        // Hand up every frame that is now in order; one ack-timer start for all.
        while (arrived[slot_t'(rcv_lo)]) begin
          push_cmd(ACT_DELIVER, rcv_lo, '0, slot_t'(rcv_lo), 1'b0, 1'b0);
          nak_ok = 1'b1;
          arrived[slot_t'(rcv_lo)] = 1'b0;
          rcv_lo = rcv_lo + seq_t'(1);
          rcv_hi = rcv_hi + seq_t'(1);
          any = 1'b1;
        end
        if (any) push_cmd(ACT_START, '0, '0, '0, 1'b0, 1'b0);
      end
    end
    if (ev.kind == KIND_NAK) begin
      want = ev.fack + seq_t'(1);
      if (in_win(snd_lo, want, snd_next)) emit_data(want);
    end
    // Retire every outstanding frame that the ack covers.
    while (in_win(snd_lo, ev.fack, snd_next)) begin
      outstanding--;
      push_cmd(ACT_STOP, snd_lo, '0, '0, 1'b0, 1'b0);
      snd_lo = snd_lo + seq_t'(1);
    end
  endfunction

  function automatic void predict_event(arq_ev_t ev);
    case (ev.mode)
      MODE_PKT_READY: begin
        if (outstanding < WIN) begin
          outstanding++;
          emit_data(snd_next);
          snd_next = snd_next + seq_t'(1);
        end
      end
      MODE_LINK_READY: link_rdy = 1'b1;
      MODE_FRAME:      predict_frame(ev);
      MODE_DATA_TMO:   emit_data(ev.tseq);
      MODE_ACK_TMO:    emit_ctrl(ACT_ACK);
      default: ;
    endcase
    push_cmd(ACT_STATUS, '0, '0, '0, (outstanding < WIN) && link_rdy, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver
  // ---------------------------------------------------------------------------

  function automatic arq_ev_t mk_ev(logic [2:0] mode, logic good, logic [1:0] kind,
                                    seq_t fseq, seq_t fack, seq_t tseq);
    arq_ev_t ev;
    ev.mode = mode;
    ev.good = good;
    ev.kind = kind;
    ev.fseq = fseq;
    ev.fack = fack;
    ev.tseq = tseq;
    return ev;
  endfunction

  // Hold the word until the engine takes it, then predict its burst. Valid stays
  // high after the handshake so back-to-back words never toggle it in one step.
  task automatic send_ev(arq_ev_t ev);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= ev.mode;
    in_if.frame_good  <= ev.good;
    in_if.frame_type  <= ev.kind;
    in_if.frame_seq   <= ev.fseq;
    in_if.ack_seq     <= ev.fack;
    in_if.timeout_seq <= ev.tseq;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    burst_len = 0;
    predict_event(ev);
    if (burst_len > max_burst) max_burst = burst_len;
    n_events++;
    if (ev.mode == MODE_FRAME) n_frames++;
  endtask

  // Ack that a sane peer would send: anything from "nothing new" up to the newest; one time in four a random number.
  function automatic seq_t peer_ack();
    if ($urandom_range(0, 3) == 0) return seq_t'($urandom);
    return snd_lo - seq_t'(1) + seq_t'($urandom_range(0, outstanding));
  endfunction

  // Mostly well-formed traffic with random content; the rest is noise.
  function automatic arq_ev_t random_ev();
    arq_ev_t     ev;
    int unsigned r;
    int unsigned k;
    ev = mk_ev(3'($urandom), 1'($urandom), 2'($urandom), seq_t'($urandom),
               seq_t'($urandom), seq_t'($urandom));
    r = $urandom_range(0, 99);
    if (r < 25) begin
      ev.mode = MODE_PKT_READY;
    end else if (r < 38) begin
      ev.mode = MODE_LINK_READY;
    end else if (r < 78) begin
      ev.mode = MODE_FRAME;
      ev.good = ($urandom_range(0, 9) != 0);
      k = $urandom_range(0, 99);
      if (k < 50)      ev.kind = KIND_DATA;
      else if (k < 75) ev.kind = KIND_ACK;
      else if (k < 95) ev.kind = KIND_NAK;
      else             ev.kind = KIND_RSVD;
      if ($urandom_range(0, 9) < 7) ev.fseq = rcv_lo + seq_t'($urandom_range(0, WIN - 1));
      ev.fack = peer_ack();
    end else if (r < 88) begin
      ev.mode = MODE_DATA_TMO;
      if ($urandom_range(0, 9) < 7) ev.tseq = snd_lo + seq_t'($urandom_range(0, outstanding));
    end else if (r < 96) begin
      ev.mode = MODE_ACK_TMO;
    end else begin
      ev.mode = MODE_RSVD_LO + 3'($urandom_range(0, 2));
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: output stalls, checker, watchdog
  // ---------------------------------------------------------------------------

  // Stall the output in bursts of random length while stalls are on.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= 1'b1;
    end
  end

  // Compare each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    arq_cmd_t got;
    arq_cmd_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.action = out_if.action;
      got.seq    = out_if.seq_number;
      got.ack    = out_if.ack_number;
      got.slot   = out_if.buffer_slot;
      got.ne     = out_if.network_enable;
      got.last   = out_if.last;
      n_words++;
      if (got.action == ACT_DELIVER) n_delivered++;
      if (got.action == ACT_STOP)    n_stops++;
      if (pending_cmds.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected word act=%0d seq=%0d ack=%0d slot=%0d ne=%0d last=%0d",
                   $realtime, got.action, got.seq, got.ack, got.slot, got.ne, got.last);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (got.action !== want.action || got.seq !== want.seq || got.ack !== want.ack ||
            got.slot !== want.slot || got.ne !== want.ne || got.last !== want.last) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: word mismatch", $realtime);
            $display("  expected act=%0d seq=%0d ack=%0d slot=%0d ne=%0d last=%0d",
                     want.action, want.seq, want.ack, want.slot, want.ne, want.last);
            $display("  actual   act=%0d seq=%0d ack=%0d slot=%0d ne=%0d last=%0d",
                     got.action, got.seq, got.ack, got.slot, got.ne, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("watchdog: no handshake for %0d cycles, %0d words still owed",
             QUIET_LIMIT, pending_cmds.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk the corner cases: full send window, timeouts, NAK suppression,
  // a whole receive window delivered by one frame, NAK resend, odd kinds and modes.
  task automatic test_directed();
    send_ev(mk_ev(MODE_LINK_READY, 1'b0, KIND_DATA, '0, '0, '0));
    for (int i = 0; i < WIN; i++)
      send_ev(mk_ev(MODE_PKT_READY, 1'b0, KIND_DATA, '0, '0, '0));
    // Window is full now: this one must be ignored.
    send_ev(mk_ev(MODE_PKT_READY, 1'b1, KIND_RSVD, '1, '1, '1));
    send_ev(mk_ev(MODE_ACK_TMO, 1'b0, KIND_DATA, '0, '0, '0));
    // Resend a number that lies outside the sender window.
    send_ev(mk_ev(MODE_DATA_TMO, 1'b0, KIND_DATA, '0, '0, '1));
    // Two bad frames: only the first one may NAK.
    send_ev(mk_ev(MODE_FRAME, 1'b0, KIND_DATA, '0, '0, '0));
    send_ev(mk_ev(MODE_FRAME, 1'b0, KIND_NAK, '1, '1, '1));
    // Fill the receive window backwards, ack nothing new.
    for (int i = WIN - 1; i >= 1; i--)
      send_ev(mk_ev(MODE_FRAME, 1'b1, KIND_DATA, seq_t'(i), '1, '0));
    // Expected frame closes the gap: full delivery plus full ack retire.
    send_ev(mk_ev(MODE_FRAME, 1'b1, KIND_DATA, '0, seq_t'(WIN - 1), '0));
    send_ev(mk_ev(MODE_PKT_READY, 1'b0, KIND_DATA, '0, '0, '0));
    send_ev(mk_ev(MODE_FRAME, 1'b1, KIND_NAK, '0, seq_t'(WIN - 1), '0));
    // Out-of-order data with NAK allowed.
    send_ev(mk_ev(MODE_FRAME, 1'b1, KIND_DATA, seq_t'(WIN + 1), seq_t'(WIN - 1), '0));
    send_ev(mk_ev(MODE_FRAME, 1'b1, KIND_RSVD, '0, seq_t'(WIN), '0));
    send_ev(mk_ev(3'h7, 1'b1, KIND_DATA, '0, '0, '0));
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_ev(random_ev());
  endtask

  // Feed runs of one frame up to a whole receive window, from its lower edge, in shuffled
  // order, with some traffic in between so the sender window keeps moving too.
  task automatic test_window_bursts(int unsigned bursts);
    int unsigned offs [WIN];
    int unsigned j;
    int unsigned tmp;
    int unsigned n;
    seq_t        base;
    for (int unsigned b = 0; b < bursts; b++) begin
      test_random_traffic($urandom_range(1, 3));
      n = $urandom_range(1, WIN);
      for (int i = 0; i < WIN; i++) offs[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = offs[i];
        offs[i] = offs[j];
        offs[j] = tmp;
      end
      base = rcv_lo;
      for (int unsigned i = 0; i < n; i++)
        send_ev(mk_ev(MODE_FRAME, ($urandom_range(0, 9) != 0), KIND_DATA,
                      base + seq_t'(offs[i]), peer_ack(), seq_t'($urandom)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_PKT_READY;
    in_if.frame_good   = 1'b0;
    in_if.frame_type   = KIND_DATA;
    in_if.frame_seq    = '0;
    in_if.ack_seq      = '0;
    in_if.timeout_seq  = '0;
    out_if.ready       = 1'b0;
    stall_left         = 0;
    stalls_on          = 1'b1;
    mismatches         = 0;
    n_events           = 0;
    n_frames           = 0;
    n_words            = 0;
    n_delivered        = 0;
    n_stops            = 0;
    max_burst          = 0;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(160);
    test_window_bursts(12);
    // Run the tail at full rate on both sides.
    stalls_on = 1'b0;
    test_random_traffic(60);

    // Drop valid, drain the owed words, then watch for strays.
    in_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += pending_cmds.size();

    $display("Ran %0d events (%0d received frames) and checked %0d command words.",
             n_events, n_frames, n_words);
    $display("Saw %0d deliveries, %0d data-timer stops, longest burst %0d words, %0d errors.",
             n_delivered, n_stops, max_burst, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
